// ===== hdl/ucml_pkg.sv =====
// package for the case map lookup block: payload structs, request codes, fsm states
// no dependencies
package ucml_pkg;

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_WR_MAP = 2'd1,
		REQ_WR_AUX = 2'd2,
		REQ_NONE   = 2'd3
	} req_type_t;

	localparam int unsigned NUM_TABLES = 3;
	localparam int unsigned RESULT_CAP = 8;
	localparam logic [20:0] CHAR_MASK = 21'h1fffff;
	localparam logic [8:0] RUN_MASK = 9'h1ff;
	localparam logic [20:0] REPLACEMENT_CHAR = 21'h00fffd;

	localparam logic [1:0] CFG_UPPER = 2'd0;
	localparam logic [1:0] CFG_LOWER = 2'd1;
	localparam logic [1:0] CFG_FOLD  = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  table_id;
		logic [11:0] slot_index;
		logic [20:0] code_point;
		logic [31:0] map_word;
		logic [15:0] aux_unit;
		logic        simple_only;
		logic [3:0]  dest_size;
	} req_t;

	typedef struct packed {
		logic [20:0] out_char;
		logic        stored;
		logic        last;
		logic [3:0]  total_len;
		logic        run_cut;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_WAIT,
		ST_CHECK,
		ST_TGT,
		ST_DEC0,
		ST_DEC1,
		ST_EMIT
	} state_t;

endpackage

// ===== hdl/unicode_case_map_lookup_core.sv =====
// Case map lookup over three sorted tables held in block memories.
//
// Channels: req (req_valid/req_stall/req) takes one transaction at a time,
// rsp (rsp_valid/rsp_stall/rsp) returns one transaction per output char.
// Configuration: cfg_we/cfg_index/cfg_data sets the three entry counts.
// Writes (req_type 1, 2) go straight to memory and produce nothing.
// A lookup binary-searches the entry memory: each probe passes through
// ST_SEARCH (midpoint), ST_WAIT (memory read) and ST_CHECK (compare).
// A complex entry then reads the aux unit memory through ST_DEC0 and
// ST_DEC1, one read per unit, so a surrogate pair takes two reads per char.
// Each char waits in the rsp output register; while rsp_stall is high the
// sequencer holds, and the next request is taken once the last char of
// the current lookup has been handed over.
// Reset clears the counts and the control state; memories are not cleared
// and an entry never written reads as anything.
// depends on ucml_pkg, ucml_map_mem, ucml_aux_mem
module unicode_case_map_lookup_core import ucml_pkg::*; #(
	parameter int unsigned MAP_DEPTH = 4096,
	parameter int unsigned AUX_DEPTH = 4096,
	parameter int unsigned MAX_RUN = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp
);
	localparam int unsigned MIW = $clog2(MAP_DEPTH);
	localparam int unsigned MCW = $clog2(MAP_DEPTH + 1);
	localparam int unsigned AIW = $clog2(AUX_DEPTH);
	localparam int unsigned MAW = MIW + 2;
	localparam int unsigned AAW = AIW + 2;
	localparam int unsigned LIMIT = (MAX_RUN < RESULT_CAP) ? MAX_RUN : RESULT_CAP;

	logic [12:0] cnt_q [NUM_TABLES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TABLES; i++) cnt_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UPPER: cnt_q[0] <= cfg_data;
				CFG_LOWER: cnt_q[1] <= cfg_data;
				CFG_FOLD:  cnt_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;
	req_t   r_q;
	logic [MCW-1:0] lo_q, hi_q;
	logic [MIW-1:0] mid_q;
	logic [31:0] tgt_q;
	logic [21:0] addr_q;
	logic [9:0]  left_q;
	logic [15:0] u0_q;
	logic [3:0]  n_q;
	logic        cut_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic [52:0] map_rd;
	logic [15:0] aux_rd;
	logic        accept;
	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE) || rsp_valid_q;

	// write path straight from the accepted transaction
	logic map_we, aux_we;
	assign map_we = accept && req.req_type == REQ_WR_MAP && req.table_id != 2'd3
		&& {20'd0, req.slot_index} < MAP_DEPTH;
	assign aux_we = accept && req.req_type == REQ_WR_AUX && req.table_id != 2'd3
		&& {20'd0, req.slot_index} < AUX_DEPTH;

	logic [MAW-1:0] map_raddr;
	logic [AAW-1:0] aux_raddr;
	logic aux_oob;
	assign map_raddr = {r_q.table_id, mid_q};
	assign aux_oob = addr_q >= 22'(AUX_DEPTH);
	assign aux_raddr = {r_q.table_id, addr_q[AIW-1:0]};

	ucml_map_mem #(.AW(MAW)) u_map (
		.clk, .we(map_we),
		.waddr({req.table_id, MIW'(req.slot_index)}),
		.wdata({req.code_point, req.map_word}),
		.raddr(map_raddr), .rdata(map_rd)
	);

	ucml_aux_mem #(.AW(AAW)) u_aux (
		.clk, .we(aux_we),
		.waddr({req.table_id, AIW'(req.slot_index)}),
		.wdata(req.aux_unit),
		.raddr(aux_raddr), .rdata(aux_rd)
	);

	logic [MCW-1:0] hi_init;
	logic [12:0] cnt_sel;
	always_comb begin
		cnt_sel = (req.table_id == 2'd3) ? 13'd0 : cnt_q[req.table_id];
		hi_init = ({19'd0, cnt_sel} > MAP_DEPTH) ? MCW'(MAP_DEPTH) : MCW'(cnt_sel);
	end

	logic [MCW:0] mid_sum;
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};

	// aux unit after oob masking; the oob flag is registered alongside the memory read
	logic oob_s1;
	logic [15:0] unit;
	assign unit = oob_s1 ? 16'd0 : aux_rd;

	logic is_sur, is_hi, is_lo;
	assign is_sur = unit[15:11] == 5'b11011;
	assign is_hi = is_sur && !unit[10];
	assign is_lo = is_sur && unit[10];

	logic emit;
	logic [20:0] emit_char;
	logic emit_last;
	logic [20:0] pair_char;
	assign pair_char = 21'h10000 + {1'b0, u0_q[9:0], unit[9:0]};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && req.req_type == REQ_LOOKUP) state_d = ST_SEARCH;
			ST_SEARCH: state_d = (lo_q < hi_q) ? ST_WAIT : ST_EMIT;
			ST_WAIT: state_d = ST_CHECK;
			ST_CHECK: begin
				if (map_rd[52:32] == r_q.code_point) state_d = ST_TGT;
				else state_d = ST_SEARCH;
			end
			ST_TGT: begin
				if (!tgt_q[31]) state_d = ST_EMIT;
				else if (!r_q.simple_only && tgt_q[29:21] == 9'd0) state_d = ST_IDLE;
				else state_d = ST_DEC0;
			end
			ST_DEC0: state_d = ST_DEC1;
			ST_DEC1: begin
				// a high surrogate goes back to read its partner unit
				if (!emit) state_d = ST_DEC0;
				else if (!rsp_valid_q || !rsp_stall) state_d = emit_last ? ST_IDLE : ST_DEC0;
			end
			ST_EMIT: if (!rsp_valid_q || !rsp_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// decode outcome in ST_DEC1 (unit of current addr, or second unit of pair)
	logic pair_phase_q;
	logic [9:0] used;
	always_comb begin
		emit = 1'b0;
		emit_char = 21'd0;
		used = 10'd1;
		if (state_q == ST_DEC1) begin
			if (pair_phase_q) begin
				emit = 1'b1;
				if (is_lo) begin
					emit_char = pair_char;
					used = 10'd2;
				end else begin
					emit_char = REPLACEMENT_CHAR;
				end
			end else if (!is_sur) begin
				emit = 1'b1;
				emit_char = {5'd0, unit};
			end else if (is_hi && left_q >= 10'd2) begin
				emit = 1'b0;
			end else begin
				emit = 1'b1;
				emit_char = REPLACEMENT_CHAR;
			end
		end
		emit_last = r_q.simple_only || (left_q <= used) ||
			(n_q + 4'd1 >= 4'(LIMIT));
	end

	logic out_free;
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			if ((state_q == ST_EMIT || (state_q == ST_DEC1 && emit)) && out_free)
				rsp_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		oob_s1 <= aux_oob;
		case (state_q)
			ST_IDLE: begin
				r_q <= req;
				lo_q <= '0;
				hi_q <= hi_init;
				n_q <= '0;
				cut_q <= 1'b0;
				tgt_q <= {11'd0, req.code_point};
				pair_phase_q <= 1'b0;
			end
			ST_SEARCH: mid_q <= mid_sum[MIW:1];
			ST_CHECK: begin
				if (map_rd[52:32] == r_q.code_point) tgt_q <= map_rd[31:0];
				else if (map_rd[52:32] < r_q.code_point)
					lo_q <= MCW'({1'b0, mid_q} + 1'b1);
				else hi_q <= MCW'(mid_q);
			end
			ST_TGT: begin
				if (r_q.simple_only) begin
					addr_q <= {1'b0, tgt_q[20:0]};
					left_q <= {9'd0, tgt_q[30]} + 10'd1;
				end else begin
					addr_q <= {1'b0, tgt_q[20:0]} + {20'd0, tgt_q[30]} + 22'd1;
					left_q <= {1'b0, tgt_q[29:21]};
				end
			end
			ST_DEC1: begin
				if (!emit) begin
					u0_q <= unit;
					pair_phase_q <= 1'b1;
					addr_q <= addr_q + 22'd1;
				end else if (out_free) begin
					pair_phase_q <= 1'b0;
					addr_q <= pair_phase_q ? ((used == 10'd2) ? addr_q + 22'd1 : addr_q)
						: addr_q + 22'd1;
					left_q <= left_q - used;
					n_q <= n_q + 4'd1;
					rsp_q.out_char <= emit_char;
					rsp_q.stored <= n_q < r_q.dest_size;
					rsp_q.last <= emit_last;
					rsp_q.total_len <= emit_last ? n_q + 4'd1 : 4'd0;
					rsp_q.run_cut <= emit_last && !r_q.simple_only && left_q > used;
					cut_q <= emit_last && left_q > used;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					rsp_q.out_char <= tgt_q[20:0] & CHAR_MASK;
					rsp_q.stored <= r_q.dest_size != 4'd0;
					rsp_q.last <= 1'b1;
					rsp_q.total_len <= 4'd1;
					rsp_q.run_cut <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef SYNTHESIS
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> req_stall)
		else $error("request taken while lookup busy");
	a_cut_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.run_cut) |-> rsp.last)
		else $error("run_cut without last");
	a_len_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.last) |-> (rsp.total_len == 4'd0))
		else $error("total_len on non-last char");
	a_cut_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(cut_q && rsp_valid) |-> rsp.last)
		else $error("cut state out of step with output");
`endif
endmodule

// ===== hdl/ucml_map_mem.sv =====
// entry memory: source code point and target word for all three tables
// depends on ucml_pkg
module ucml_map_mem import ucml_pkg::*; #(
	parameter int unsigned AW = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [52:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [52:0]   rdata
);
	localparam int unsigned DEPTH = 1 << AW;
	logic [52:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/ucml_aux_mem.sv =====
// auxiliary utf-16 unit memory for all three tables
// depends on ucml_pkg
module ucml_aux_mem import ucml_pkg::*; #(
	parameter int unsigned AW = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);
	localparam int unsigned DEPTH = 1 << AW;
	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== test/unicode_case_map_lookup_core_test.sv =====
// testbench for unicode_case_map_lookup_core: queue-fed driver, checking monitor, own predictor
// depends on ucml_pkg and the core under hdl
`timescale 1ns / 100ps

module unicode_case_map_lookup_core_test;
	import ucml_pkg::*;

	localparam int unsigned MAP_DEPTH = 4096;
	localparam int unsigned AUX_DEPTH = 4096;
	localparam int unsigned MAX_RUN = 8;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned SETTLE_CYCLES = 60;
	localparam int unsigned LONG_HOLD = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;

	unicode_case_map_lookup_core #(
		.MAP_DEPTH(MAP_DEPTH),
		.AUX_DEPTH(AUX_DEPTH),
		.MAX_RUN(MAX_RUN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	// shadow copy of the tables, aux units and counts
	logic [20:0] map_src[3][MAP_DEPTH];
	logic [31:0] map_tgt[3][MAP_DEPTH];
	logic [15:0] aux_mem[3][AUX_DEPTH];
	int unsigned entry_cnt[3];

	req_t req_backlog[$];
	rsp_t expected_chars[$];
	int unsigned mismatches = 0;
	bit no_idle = 1'b0;
	int unsigned hold_requests = 0;
	int unsigned idle_cycles = 0;

	function automatic logic [15:0] aux_fetch(int unsigned t, int unsigned a);
		if (a >= AUX_DEPTH) return 16'h0;
		return aux_mem[t][a];
	endfunction

	// returns units consumed
	function automatic int unsigned decode_utf16(int unsigned t, int unsigned a,
			int unsigned avail, output logic [20:0] ch);
		int unsigned u0, u1;
		u0 = aux_fetch(t, a);
		if (u0 < 'hd800 || u0 > 'hdfff) begin
			ch = 21'(u0);
			return 1;
		end
		if (u0 <= 'hdbff && avail >= 2) begin
			u1 = aux_fetch(t, a + 1);
			if (u1 >= 'hdc00 && u1 <= 'hdfff) begin
				ch = 21'('h10000 + ((u0 - 'hd800) << 10) + (u1 - 'hdc00));
				return 2;
			end
		end
		ch = REPLACEMENT_CHAR;
		return 1;
	endfunction

	task automatic predict_case_map(input req_t r);
		int unsigned t, lo, hi, mid, offs, runlen, addr, used, n, lim;
		logic found, cut;
		logic [31:0] tg;
		logic [20:0] ch;
		logic [20:0] chars[RESULT_CAP];
		rsp_t e;
		t = r.table_id;
		n = 0;
		cut = 1'b0;
		found = 1'b0;
		tg = '0;
		lim = (MAX_RUN < RESULT_CAP) ? MAX_RUN : RESULT_CAP;
		case (r.req_type)
			REQ_WR_MAP: begin
				if (t < NUM_TABLES) begin
					map_src[t][r.slot_index] = r.code_point;
					map_tgt[t][r.slot_index] = r.map_word;
				end
				return;
			end
			REQ_WR_AUX: begin
				if (t < NUM_TABLES) aux_mem[t][r.slot_index] = r.aux_unit;
				return;
			end
			REQ_NONE: return;
			default: ;
		endcase
		lo = 0;
		hi = 0;
		if (t < NUM_TABLES) hi = (entry_cnt[t] > MAP_DEPTH) ? MAP_DEPTH : entry_cnt[t];
		while (lo < hi) begin
			mid = (lo + hi) >> 1;
			if (map_src[t][mid] == r.code_point) begin
				found = 1'b1;
				tg = map_tgt[t][mid];
				break;
			end
			if (map_src[t][mid] < r.code_point) lo = mid + 1;
			else hi = mid;
		end
		if (!found) begin
			chars[n++] = r.code_point;
		end else if (!tg[31]) begin
			chars[n++] = tg[20:0];
		end else begin
			offs = tg[20:0];
			runlen = tg[29:21];
			if (r.simple_only) begin
				used = decode_utf16(t, offs, tg[30] + 1, ch);
				chars[n++] = ch;
			end else begin
				addr = offs + tg[30] + 1;
				while (runlen > 0) begin
					if (n >= lim) begin
						cut = 1'b1;
						break;
					end
					used = decode_utf16(t, addr, runlen, ch);
					chars[n++] = ch;
					runlen -= used;
					addr += used;
				end
			end
		end
		for (int unsigned k = 0; k < n; k++) begin
			e.out_char = chars[k];
			e.stored = (k < r.dest_size);
			e.last = (k + 1 == n);
			e.total_len = e.last ? n[3:0] : 4'd0;
			e.run_cut = e.last && cut;
			expected_chars.push_back(e);
		end
	endtask

	// driver: one transaction offered at a time, random gap after each unless no_idle is set
	int unsigned send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				predict_case_map(req);
				send_gap = no_idle ? 0 : $urandom_range(0, 10);
			end
			if ((req_valid && !req_stall) || !req_valid) begin
				if (send_gap == 0 && req_backlog.size() > 0) begin
					req <= req_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
					if (send_gap > 0) send_gap--;
				end
			end
		end
	end

	// monitor: random stall per char unless no_idle is set, long hold on request
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	int unsigned holds_done = 0;
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected char %h", rsp.out_char);
					mismatches++;
				end else begin
					e = expected_chars.pop_front();
					if (rsp.out_char !== e.out_char) begin
						$error("out_char expected %h got %h", e.out_char, rsp.out_char);
						mismatches++;
					end
					if (rsp.stored !== e.stored) begin
						$error("stored expected %b got %b", e.stored, rsp.stored);
						mismatches++;
					end
					if (rsp.last !== e.last) begin
						$error("last expected %b got %b", e.last, rsp.last);
						mismatches++;
					end
					if (rsp.total_len !== e.total_len) begin
						$error("total_len expected %0d got %0d", e.total_len, rsp.total_len);
						mismatches++;
					end
					if (rsp.run_cut !== e.run_cut) begin
						$error("run_cut expected %b got %b", e.run_cut, rsp.run_cut);
						mismatches++;
					end
				end
				stall_left = no_idle ? 0 : $urandom_range(0, 10);
			end
			if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic drain_block();
		while (req_backlog.size() > 0 || req_valid || expected_chars.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_counts(input int unsigned cu, input int unsigned cl, input int unsigned cf);
		logic [1:0] idx[3];
		int unsigned vals[3];
		idx = '{CFG_UPPER, CFG_LOWER, CFG_FOLD};
		vals = '{cu, cl, cf};
		for (int i = 0; i < 3; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= 13'(vals[i]);
			entry_cnt[i] = vals[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic req_t random_req(input logic [1:0] kind, input int unsigned t);
		req_t r;
		r.req_type = kind;
		r.table_id = 2'(t);
		r.slot_index = 12'($urandom);
		r.code_point = 21'($urandom);
		r.map_word = $urandom;
		r.aux_unit = 16'($urandom);
		r.simple_only = 1'($urandom);
		r.dest_size = 4'($urandom_range(0, 8));
		return r;
	endfunction

	function automatic logic [31:0] make_target();
		logic [31:0] w;
		logic [8:0] runlen;
		w = $urandom;
		runlen = ($urandom_range(0, 7) == 0) ? 9'd0 : 9'($urandom);
		case ($urandom_range(0, 5))
			0, 1: w[31] = 1'b0;
			5: begin
				// unit addresses at the top of the store or past its end
				w[31] = 1'b1;
				w[29:21] = runlen;
				w[20:0] = $urandom_range(0, 1) ? 21'd4093 : 21'($urandom_range(4096, 'h1fffff));
			end
			default: begin
				w[31] = 1'b1;
				w[29:21] = runlen;
				w[20:0] = 21'($urandom_range(0, 16));
			end
		endcase
		return w;
	endfunction

	task automatic fill_tables();
		req_t r;
		int unsigned src;
		for (int t = 0; t < 3; t++) begin
			src = $urandom_range(0, 1) ? 0 : $urandom_range(0, 300);
			for (int unsigned i = 0; i < entry_cnt[t]; i++) begin
				r = random_req(REQ_WR_MAP, t);
				r.slot_index = 12'(i);
				if (i + 1 == entry_cnt[t] && entry_cnt[t] < 64 && $urandom_range(0, 1))
					src = 'h1fffff;
				r.code_point = 21'(src);
				r.map_word = make_target();
				req_backlog.push_back(r);
				src += $urandom_range(1, 400);
			end
		end
	endtask

	function automatic req_t lookup_item(input int unsigned t);
		req_t r;
		r = random_req(REQ_LOOKUP, t);
		if (t < 3 && entry_cnt[t] > 0 && $urandom_range(0, 9) < 7)
			r.code_point = map_src[t][$urandom_range(0, entry_cnt[t] - 1)];
		return r;
	endfunction

	// writes and ignored requests that never make a lookup read unwritten storage
	function automatic req_t noise_item();
		req_t r;
		int unsigned t;
		t = $urandom_range(0, 2);
		case ($urandom_range(0, 3))
			0: r = random_req(REQ_NONE, $urandom_range(0, 3));
			1: r = random_req($urandom_range(0, 1) ? REQ_WR_MAP : REQ_WR_AUX, 3);
			2: begin
				r = random_req(REQ_WR_AUX, t);
				r.slot_index = 12'($urandom_range(64, 4089));
			end
			default: begin
				if (entry_cnt[t] < MAP_DEPTH) begin
					r = random_req(REQ_WR_MAP, t);
					r.slot_index = 12'($urandom_range(entry_cnt[t], MAP_DEPTH - 1));
				end else begin
					r = random_req(REQ_NONE, t);
				end
			end
		endcase
		return r;
	endfunction

	task automatic run_lookups(input int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 6) == 0) req_backlog.push_back(noise_item());
			else req_backlog.push_back(lookup_item($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2)));
		end
	endtask

	initial begin
		req_t r;
		int unsigned u;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// empty tables: everything passes through
		set_counts(0, 0, 0);
		for (int t = 0; t < 4; t++) begin
			r = random_req(REQ_LOOKUP, t);
			r.code_point = (t % 2) ? 21'h1fffff : 21'h0;
			r.dest_size = (t % 2) ? 4'd8 : 4'd0;
			req_backlog.push_back(r);
		end
		req_backlog.push_back(random_req(REQ_NONE, 0));
		req_backlog.push_back(random_req(REQ_WR_MAP, 3));
		req_backlog.push_back(random_req(REQ_WR_AUX, 3));

		// aux units: low region and top of each store, surrogates mixed in
		no_idle = 1'b1;
		for (int t = 0; t < 3; t++) begin
			for (int unsigned a = 0; a < AUX_DEPTH; a++) begin
				if (a < 36 || a >= 4090) begin
					r = random_req(REQ_WR_AUX, t);
					r.slot_index = 12'(a);
					case ($urandom_range(0, 3))
						0: u = $urandom_range('hd800, 'hdbff);
						1: u = $urandom_range('hdc00, 'hdfff);
						default: u = $urandom_range(0, 'hffff);
					endcase
					r.aux_unit = 16'(u);
					req_backlog.push_back(r);
				end
			end
		end
		drain_block();
		no_idle = 1'b0;

		// small tables, each entry looked up in both modes
		set_counts(6, 3, 1);
		fill_tables();
		drain_block();
		for (int t = 0; t < 3; t++) begin
			for (int unsigned i = 0; i < entry_cnt[t]; i++) begin
				r = random_req(REQ_LOOKUP, t);
				r.code_point = map_src[t][i];
				r.simple_only = 1'b0;
				req_backlog.push_back(r);
				r.simple_only = 1'b1;
				req_backlog.push_back(r);
			end
		end
		drain_block();

		// larger upper table for deeper searches
		no_idle = 1'b1;
		set_counts(48, 0, 2);
		fill_tables();
		drain_block();
		no_idle = 1'b0;
		run_lookups(30);
		drain_block();

		for (int ph = 0; ph < 6; ph++) begin
			set_counts(ph == 3 ? 0 : $urandom_range(1, 8), $urandom_range(1, 8),
				ph == 5 ? 0 : $urandom_range(1, 8));
			fill_tables();
			drain_block();
			no_idle = (ph % 3 == 2);
			if (ph == 4) hold_requests++;
			run_lookups(20);
			drain_block();
			no_idle = 1'b0;
		end

		drain_block();
		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
